>>> hw/rtl/crc8_block_packet_framer_defines.svh
// assertion macros shared by the packet framer rtl
// no dependencies; included by files that carry assertions
`ifndef CRC8_BLOCK_PACKET_FRAMER_DEFINES_SVH
`define CRC8_BLOCK_PACKET_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check on every clock edge outside reset
`define CBPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define CBPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBPF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/cbpf_pkg.sv
// shared types, framing bytes and crc-8 step for the packet framer
// no dependencies; imported by every framer module
package cbpf_pkg;

    localparam int DEF_BLOCK_BYTES = 16;

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_PAD = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // which packet byte the sequencer sends next
    typedef enum logic [2:0] {
        PH_STX,
        PH_DATA,
        PH_PAD,
        PH_CRC,
        PH_ETX
    } phase_t;

    // one packet byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } result_t;

    // reflected dallas/maxim crc-8, one byte, lsb first
    function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] crc_in,
                                                   input logic [7:0] byte_in);
        logic [7:0] c;
        logic [7:0] b;
        logic       mix;
        c = crc_in;
        b = byte_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = c[0] ^ b[0];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            b = {1'b0, b[7:1]};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crc8_block_packet_framer.sv
// top level of the stx/etx packet framer with crc-8
// depends on cbpf_pkg, cbpf_seq and cbpf_out_reg
//
// usage:
//   input stream (s_*): one image byte per item in s_tdata, s_tlast high on the
//   final byte of the image. output stream (m_*): one packet byte per item;
//   m_tlast marks the closing etx of a packet, m_tuser marks the last byte
//   caused by an input item.
//   every BLOCK_BYTES input bytes form one packet: stx, data, crc, etx.
//   s_tlast closes the open block early, padded with 0xff (pad counted in crc).
//   crc is reflected crc-8, poly 0x8c, init 0, restarted with each packet.
// timing:
//   the output port sends one byte per cycle while m_tready is high, so an input
//   item yields 1 to BLOCK_BYTES+3 output bytes (2 typical for the byte that opens
//   a block, 1 for a middle byte, 3 or more for a byte that closes one).
//   the first output byte of an item passes the item register and then the
//   output register before it is on m_*.
//   the next item is taken in the same cycle as the last byte of the current one
//   moves into the output register, so there are no gaps between items.
// reset: rst_n clears both stages, block position and crc; the next item opens
//   a fresh packet.
// stall: with m_tready low the output register holds its byte, the sequencer
//   freezes and s_tready drops once the item register is busy.
module crc8_block_packet_framer
    import cbpf_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // packet_end
    output logic       m_tuser    // [0] run_last
);

    logic    take;
    logic    res_valid;
    result_t res;

    // packet byte sequencer, one byte per cycle when the output stage takes it
    cbpf_seq #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register decouples the sequencer from the receiver
    cbpf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> hw/rtl/cbpf_out_reg.sv
// output register stage of the packet framer
// depends on cbpf_pkg (result_t)
module cbpf_out_reg
    import cbpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  result_t    res,
    output logic       take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // packet_end
    output logic       m_tuser    // [0] run_last
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // register is free when empty or being drained this cycle
    assign take = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tlast  = res_reg.packet_end;
    assign m_tuser  = res_reg.run_last;

endmodule

>>> hw/rtl/cbpf_seq.sv
// item register and packet byte sequencer with block position and running crc
// depends on cbpf_pkg and crc8_block_packet_framer_defines.svh
`include "crc8_block_packet_framer_defines.svh"

module cbpf_seq
    import cbpf_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       take,
    output logic       res_valid,
    output result_t    res
);

    localparam int PW = $clog2(BLOCK_BYTES + 1);
    localparam logic [PW-1:0] POS_END = PW'(BLOCK_BYTES);

    logic          item_valid_reg;
    logic          item_valid_next;
    logic [7:0]    data_reg;
    logic          final_reg;
    phase_t        phase_reg;
    phase_t        phase_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [7:0]    crc_reg;
    logic [7:0]    crc_next;

    phase_t        phase_adv;
    logic [PW-1:0] pos_adv;
    logic [7:0]    crc_adv;
    logic [PW-1:0] pos_inc;
    logic          at_end;
    logic [7:0]    crc_step;
    logic          fire;
    logic          accept;

    assign pos_inc  = pos_reg + PW'(1);
    assign at_end   = (pos_inc == POS_END);
    assign crc_step = crc8_maxim_byte(crc_reg, (phase_reg == PH_PAD) ? BYTE_PAD : data_reg);

    // output byte and the state it leaves behind
    always_comb
    begin
        res.out_byte   = BYTE_STX;
        res.packet_end = 1'b0;
        res.run_last   = 1'b0;
        phase_adv      = phase_reg;
        pos_adv        = pos_reg;
        crc_adv        = crc_reg;
        case (phase_reg)
            PH_STX:
            begin
                res.out_byte = BYTE_STX;
                phase_adv    = PH_DATA;
            end
            PH_DATA:
            begin
                res.out_byte = data_reg;
                crc_adv      = crc_step;
                pos_adv      = pos_inc;
                if (at_end)
                begin
                    phase_adv = PH_CRC;
                end
                else if (final_reg)
                begin
                    phase_adv = PH_PAD;
                end
                else
                begin
                    res.run_last = 1'b1;
                end
            end
            PH_PAD:
            begin
                res.out_byte = BYTE_PAD;
                crc_adv      = crc_step;
                pos_adv      = pos_inc;
                phase_adv    = at_end ? PH_CRC : PH_PAD;
            end
            PH_CRC:
            begin
                res.out_byte = crc_reg;
                phase_adv    = PH_ETX;
            end
            PH_ETX:
            begin
                res.out_byte   = BYTE_ETX;
                res.packet_end = 1'b1;
                res.run_last   = 1'b1;
                pos_adv        = '0;
                crc_adv        = '0;
            end
            default:
            begin
                res.out_byte = BYTE_STX;
            end
        endcase
    end

    assign res_valid = item_valid_reg;
    assign fire      = item_valid_reg && take;
    // next item may enter while the last byte of this one moves out
    assign s_tready  = !item_valid_reg || (take && res.run_last);
    assign accept    = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        pos_next        = fire ? pos_adv : pos_reg;
        crc_next        = fire ? crc_adv : crc_reg;
        phase_next      = phase_reg;
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            phase_next      = (pos_next == '0) ? PH_STX : PH_DATA;
        end
        else if (fire)
        begin
            phase_next = phase_adv;
            if (res.run_last)
            begin
                item_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_STX;
            pos_reg        <= '0;
            crc_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= s_tdata;
            final_reg <= s_tlast;
        end
    end

    `CBPF_ASSERT_ALWAYS(a_pos_range, clk, (!rst_n || pos_reg <= POS_END), "block position out of range")
    `CBPF_ASSERT(a_stx_at_start, clk, rst_n, (item_valid_reg && phase_reg == PH_STX) |-> (pos_reg == '0 && crc_reg == '0), "stx pending with block already open")
    `CBPF_ASSERT(a_pad_in_block, clk, rst_n, (item_valid_reg && phase_reg == PH_PAD) |-> (pos_reg != '0 && pos_reg != POS_END), "pad outside an open block")
    `CBPF_ASSERT(a_etx_clears, clk, rst_n, (fire && phase_reg == PH_ETX) |=> (pos_reg == '0 && crc_reg == '0), "block state not cleared after etx")

endmodule
